>>> rtl/tep_pkg.sv
// Shared constants for the triangle plane equation pipeline.
// Output field widths, fixed-point unit values and offset clamp limits.
// No dependencies.
`default_nettype none
package tep_pkg;
	localparam int NORM_W   = 16;
	localparam int OFF_W    = 26;
	localparam int THR_W    = 32;
	localparam int QBITS    = 15;
	localparam int OUT_TW   = 80;
	localparam logic [THR_W-1:0] THR_RESET = 32'd1;
	localparam logic signed [NORM_W-1:0] UNIT_Q14 = 16'sd16384;
	localparam logic signed [63:0] OFFSET_MAX = 64'sd33554431;
	localparam logic signed [63:0] OFFSET_MIN = -64'sd33554432;
	localparam logic [63:0] HALF_LSB = 64'd8192;
endpackage
`default_nettype wire

>>> rtl/triangle_plane_equation.sv
// Triangle plane equation: cross product, length, unit normal and plane offset.
// Depends on tep_pkg.
//
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Stages: edges, products, cross terms, square partials, squares, sum, one stage
// per root bit, threshold compare, 15 quotient stages, sign, dot products, sum, round.
// Reset clears the valid bits and sets the threshold to 1; data registers are not reset.
`default_nettype none
module triangle_plane_equation #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [tep_pkg::THR_W-1:0] cfg_wr_data,
	input  wire logic s_tvalid,
	output logic s_tready,
	// ax, ay, az, bx, by_coord, bz, cx, cy, cz (COORD_WIDTH each), zero pad
	input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  wire logic m_tready,
	// normal_x[15:0], normal_y[31:16], normal_z[47:32], plane_offset[73:48], zero pad
	output logic [tep_pkg::OUT_TW-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);
	import tep_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int EW   = W + 1;
	localparam int MW   = 2 * EW;
	localparam int H    = (MW + 1) / 2;
	localparam int HW   = MW - H;
	localparam int SQW  = 2 * MW + 2;
	localparam int LW   = MW + 1;
	localparam int RW   = LW + 2;
	localparam int NW   = MW + 16;
	localparam int PW   = W + NORM_W;
	localparam int DW   = W + NORM_W + 2;
	localparam int UW   = DW - 12;
	localparam int NSTG = LW + 26;

	logic en;
	logic [NSTG-1:0] vld_q;
	logic [THR_W-1:0] thr_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], s_tvalid};
		end
	end

	// stage 1: edges
	logic signed [2:0][W-1:0] a_s1;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= s_tdata[i*W +: W];
				e1_s1[i] <= EW'(signed'(s_tdata[(3+i)*W +: W])) - EW'(signed'(s_tdata[i*W +: W]));
				e2_s1[i] <= EW'(signed'(s_tdata[(6+i)*W +: W])) - EW'(signed'(s_tdata[i*W +: W]));
			end
		end
	end

	// stage 2: edge products
	logic signed [2:0][W-1:0] a_s2;
	logic signed [MW-1:0] pp_s2 [3];
	logic signed [MW-1:0] pn_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			pp_s2[0] <= e1_s1[1] * e2_s1[2];
			pn_s2[0] <= e1_s1[2] * e2_s1[1];
			pp_s2[1] <= e1_s1[2] * e2_s1[0];
			pn_s2[1] <= e1_s1[0] * e2_s1[2];
			pp_s2[2] <= e1_s1[0] * e2_s1[1];
			pn_s2[2] <= e1_s1[1] * e2_s1[0];
		end
	end

	// stage 3: cross terms as sign and magnitude
	logic signed [2:0][W-1:0] a_s3;
	logic [2:0][MW-1:0] m_s3;
	logic [2:0] neg_s3;
	logic signed [MW:0] diff [3];
	logic [MW:0] diff_abs [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {pp_s2[i][MW-1], pp_s2[i]} - {pn_s2[i][MW-1], pn_s2[i]};
			diff_abs[i] = diff[i][MW] ? (MW+1)'(-diff[i]) : diff[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= a_s2;
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= diff[i][MW];
				m_s3[i] <= diff_abs[i][MW-1:0];
			end
		end
	end

	// stage 4: square partial products
	logic signed [2:0][W-1:0] a_s4;
	logic [2:0][MW-1:0] m_s4;
	logic [2:0] neg_s4;
	logic [2*HW-1:0] hh_s4 [3];
	logic [MW-1:0] hl_s4 [3];
	logic [2*H-1:0] ll_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= a_s3;
			m_s4 <= m_s3;
			neg_s4 <= neg_s3;
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= (2*HW)'(m_s3[i][MW-1:H]) * (2*HW)'(m_s3[i][MW-1:H]);
				hl_s4[i] <= MW'(m_s3[i][MW-1:H]) * MW'(m_s3[i][H-1:0]);
				ll_s4[i] <= (2*H)'(m_s3[i][H-1:0]) * (2*H)'(m_s3[i][H-1:0]);
			end
		end
	end

	// stage 5: squares
	logic signed [2:0][W-1:0] a_s5;
	logic [2:0][MW-1:0] m_s5;
	logic [2:0] neg_s5;
	logic [2*MW-1:0] sq_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5 <= a_s4;
			m_s5 <= m_s4;
			neg_s5 <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= ((2*MW)'(hh_s4[i]) << (2*H)) + ((2*MW)'(hl_s4[i]) << (H+1))
					+ (2*MW)'(ll_s4[i]);
			end
		end
	end

	// stage 6: sum of squares
	logic signed [2:0][W-1:0] a_s6;
	logic [2:0][MW-1:0] m_s6;
	logic [2:0] neg_s6;
	logic [SQW-1:0] sum_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s6 <= a_s5;
			m_s6 <= m_s5;
			neg_s6 <= neg_s5;
			sum_s6 <= SQW'(sq_s5[0]) + SQW'(sq_s5[1]) + SQW'(sq_s5[2]);
		end
	end

	// square root, one root bit per stage
	logic signed [2:0][W-1:0] rt_a [LW+1];
	logic [2:0][MW-1:0] rt_m [LW+1];
	logic [2:0] rt_neg [LW+1];
	logic [SQW-1:0] rt_n [LW+1];
	logic [RW-1:0] rt_rem [LW+1];
	logic [LW-1:0] rt_root [LW+1];

	assign rt_a[0]    = a_s6;
	assign rt_m[0]    = m_s6;
	assign rt_neg[0]  = neg_s6;
	assign rt_n[0]    = sum_s6;
	assign rt_rem[0]  = '0;
	assign rt_root[0] = '0;

	for (genvar k = 0; k < LW; k++) begin : g_root
		logic [RW-1:0] remx;
		logic [RW-1:0] trial;
		logic ge;

		assign remx  = {rt_rem[k][RW-3:0], rt_n[k][SQW-1:SQW-2]};
		assign trial = {rt_root[k], 2'b01};
		assign ge    = remx >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_a[k+1] <= rt_a[k];
				rt_m[k+1] <= rt_m[k];
				rt_neg[k+1] <= rt_neg[k];
				rt_n[k+1] <= {rt_n[k][SQW-3:0], 2'b00};
				rt_rem[k+1] <= ge ? remx - trial : remx;
				rt_root[k+1] <= {rt_root[k][LW-2:0], ge};
			end
		end
	end

	// threshold compare
	logic signed [2:0][W-1:0] a_sc;
	logic [2:0][MW-1:0] m_sc;
	logic [2:0] neg_sc;
	logic [LW-1:0] len_sc;
	logic degen_sc;

	always_ff @(posedge clk) begin
		if (en) begin
			a_sc <= rt_a[LW];
			m_sc <= rt_m[LW];
			neg_sc <= rt_neg[LW];
			len_sc <= rt_root[LW];
			degen_sc <= rt_root[LW] <= LW'(thr_q);
		end
	end

	// rounded division, one quotient bit per stage
	logic signed [2:0][W-1:0] dv_a [QBITS+1];
	logic [2:0] dv_neg [QBITS+1];
	logic dv_degen [QBITS+1];
	logic [LW:0] dv_den [QBITS+1];
	logic [2:0][NW-1:0] dv_rem [QBITS+1];
	logic [2:0][QBITS-1:0] dv_q [QBITS+1];

	assign dv_a[0]     = a_sc;
	assign dv_neg[0]   = neg_sc;
	assign dv_degen[0] = degen_sc;
	assign dv_den[0]   = {len_sc, 1'b0};
	assign dv_q[0]     = '0;
	for (genvar c = 0; c < 3; c++) begin : g_num
		assign dv_rem[0][c] = NW'({m_sc[c], 15'd0}) + NW'(len_sc);
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_div
		logic [NW-1:0] dsh;
		logic [2:0] ge;

		assign dsh = NW'(dv_den[j]) << (QBITS - 1 - j);
		always_comb begin
			for (int c = 0; c < 3; c++) begin
				ge[c] = dv_rem[j][c] >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_a[j+1] <= dv_a[j];
				dv_neg[j+1] <= dv_neg[j];
				dv_degen[j+1] <= dv_degen[j];
				dv_den[j+1] <= dv_den[j];
				for (int c = 0; c < 3; c++) begin
					dv_rem[j+1][c] <= ge[c] ? dv_rem[j][c] - dsh : dv_rem[j][c];
					dv_q[j+1][c] <= {dv_q[j][c][QBITS-2:0], ge[c]};
				end
			end
		end
	end

	// sign and degenerate override
	logic signed [2:0][W-1:0] a_sn;
	logic signed [NORM_W-1:0] n_sn [3];
	logic degen_sn;

	always_ff @(posedge clk) begin
		if (en) begin
			a_sn <= dv_a[QBITS];
			degen_sn <= dv_degen[QBITS];
			for (int c = 0; c < 3; c++) begin
				if (dv_degen[QBITS]) begin
					n_sn[c] <= UNIT_Q14;
				end else if (dv_neg[QBITS][c]) begin
					n_sn[c] <= -NORM_W'(dv_q[QBITS][c]);
				end else begin
					n_sn[c] <= NORM_W'(dv_q[QBITS][c]);
				end
			end
		end
	end

	// dot products
	logic signed [NORM_W-1:0] n_sm [3];
	logic signed [PW-1:0] pr_sm [3];
	logic degen_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			degen_sm <= degen_sn;
			for (int c = 0; c < 3; c++) begin
				n_sm[c] <= n_sn[c];
				pr_sm[c] <= n_sn[c] * signed'(a_sn[c]);
			end
		end
	end

	// dot sum
	logic signed [NORM_W-1:0] n_sd [3];
	logic signed [DW-1:0] dot_sd;
	logic degen_sd;

	always_ff @(posedge clk) begin
		if (en) begin
			degen_sd <= degen_sm;
			n_sd <= n_sm;
			dot_sd <= DW'(pr_sm[0]) + DW'(pr_sm[1]) + DW'(pr_sm[2]);
		end
	end

	// round, negate and clamp
	logic [DW-1:0] dot_abs;
	logic [DW:0] dot_rnd;
	logic signed [UW-1:0] d_val;
	logic signed [63:0] d_ext;
	logic signed [OFF_W-1:0] d_sat;

	always_comb begin
		dot_abs = dot_sd[DW-1] ? DW'(-dot_sd) : dot_sd;
		dot_rnd = (DW+1)'(dot_abs) + (DW+1)'(HALF_LSB);
		if (!dot_sd[DW-1] && dot_sd != '0) begin
			d_val = -UW'(dot_rnd[DW:14]);
		end else begin
			d_val = UW'(dot_rnd[DW:14]);
		end
		d_ext = 64'(d_val);
		priority if (d_ext > OFFSET_MAX) begin
			d_sat = OFF_W'(OFFSET_MAX);
		end else if (d_ext < OFFSET_MIN) begin
			d_sat = OFF_W'(OFFSET_MIN);
		end else begin
			d_sat = OFF_W'(d_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {6'd0, d_sat, n_sd[2], n_sd[1], n_sd[0]};
			m_tuser <= degen_sd;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] == UNIT_Q14 && m_tdata[31:16] == UNIT_Q14
			&& m_tdata[47:32] == UNIT_Q14)
		else $error("degenerate item without unit normal");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= UNIT_Q14 && $signed(m_tdata[15:0]) >= -UNIT_Q14)
		else $error("normal x out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TW-1:74] == '0)
		else $error("nonzero pad bits");
endmodule
`default_nettype wire

>>> sim/tb_triangle_plane_equation.sv
// Self-checking testbench for triangle_plane_equation: streams triangles under random
// idling on both sides, sweeps the degenerate threshold and checks every result.
// Depends on tep_pkg and the triangle_plane_equation RTL.
`timescale 1ns / 100ps
module tb_triangle_plane_equation;
	import tep_pkg::*;

	localparam int CW = 24;
	localparam int LATENCY = 2 * CW + 29;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_PER_PHASE = 130;

	typedef struct {
		logic signed [CW-1:0] v [9];
	} tri_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [OFF_W-1:0] off;
		logic degen;
	} plane_t;

	typedef struct {
		tri_t t;
		bit typed;
		plane_t e;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [THR_W-1:0] cfg_wr_data;
	logic s_tvalid;
	logic s_tready;
	logic [9*CW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TW-1:0] m_tdata;
	logic m_tuser;

	plane_t planes_due [$];
	row_t dir_rows [$];
	logic [THR_W-1:0] thr_now;
	int mismatches;
	int cycles;
	bit tx_idle;
	bit rx_idle;

	triangle_plane_equation #(.COORD_WIDTH(CW)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic plane_t plane_of(tri_t t, logic [THR_W-1:0] thr);
		longint a [3];
		longint e1 [3];
		longint e2 [3];
		longint x [3];
		longint n [3];
		logic [127:0] mg [3];
		logic [127:0] sum;
		logic [127:0] len;
		logic [127:0] cand;
		logic [127:0] q;
		longint dot;
		longint u;
		longint d;
		plane_t p;
		for (int i = 0; i < 3; i++) begin
			a[i] = t.v[i];
			e1[i] = longint'(t.v[3+i]) - a[i];
			e2[i] = longint'(t.v[6+i]) - a[i];
		end
		x[0] = e1[1] * e2[2] - e1[2] * e2[1];
		x[1] = e1[2] * e2[0] - e1[0] * e2[2];
		x[2] = e1[0] * e2[1] - e1[1] * e2[0];
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = x[i] < 0 ? 128'(-x[i]) : 128'(x[i]);
			sum = sum + mg[i] * mg[i];
		end
		len = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = len | (128'd1 << i);
			if (cand * cand <= sum)
				len = cand;
		end
		p.degen = len <= {96'd0, thr};
		for (int i = 0; i < 3; i++) begin
			if (p.degen) begin
				n[i] = 16384;
			end else begin
				q = ((mg[i] << 15) + len) / (len << 1);
				n[i] = x[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
		dot = n[0] * a[0] + n[1] * a[1] + n[2] * a[2];
		u = ((dot < 0 ? -dot : dot) + 8192) >>> 14;
		d = dot > 0 ? -u : u;
		if (d > 33554431)
			d = 33554431;
		if (d < -33554432)
			d = -33554432;
		p.nx = n[0][NORM_W-1:0];
		p.ny = n[1][NORM_W-1:0];
		p.nz = n[2][NORM_W-1:0];
		p.off = d[OFF_W-1:0];
		return p;
	endfunction

	function automatic tri_t mk(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		tri_t t;
		t.v[0] = ax[CW-1:0]; t.v[1] = ay[CW-1:0]; t.v[2] = az[CW-1:0];
		t.v[3] = bx[CW-1:0]; t.v[4] = by[CW-1:0]; t.v[5] = bz[CW-1:0];
		t.v[6] = cx[CW-1:0]; t.v[7] = cy[CW-1:0]; t.v[8] = cz[CW-1:0];
		return t;
	endfunction

	function automatic plane_t pl(int nx, int ny, int nz, int off, bit dg);
		plane_t p;
		p.nx = nx[NORM_W-1:0];
		p.ny = ny[NORM_W-1:0];
		p.nz = nz[NORM_W-1:0];
		p.off = off[OFF_W-1:0];
		p.degen = dg;
		return p;
	endfunction

	task automatic add_row(tri_t t, bit typed, plane_t e);
		row_t r;
		r.t = t;
		r.typed = typed;
		r.e = e;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic send_tri(tri_t t, bit typed, plane_t e);
		int gap;
		logic [9*CW-1:0] packed_v;
		plane_t due;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		for (int i = 0; i < 9; i++)
			packed_v[i*CW +: CW] = t.v[i];
		s_tdata <= packed_v;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		due = typed ? e : plane_of(t, thr_now);
		planes_due.insert(planes_due.size(), due);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (planes_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_thr(logic [THR_W-1:0] val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_now = val;
	endtask

	function automatic int coord();
		logic [31:0] r;
		r = $urandom;
		return int'(signed'(r[CW-1:0]));
	endfunction

	function automatic tri_t rand_tri();
		int a [3];
		int b [3];
		int c [3];
		int s;
		int kind;
		kind = $urandom_range(0, 3);
		case ($urandom_range(0, 3))
			0: s = 2;
			1: s = 40;
			2: s = 5000;
			default: s = 200000;
		endcase
		for (int i = 0; i < 3; i++) begin
			a[i] = coord();
			b[i] = a[i] + $urandom_range(0, 2 * s) - s;
			c[i] = a[i] + $urandom_range(0, 2 * s) - s;
		end
		if (kind == 0) begin
			for (int i = 0; i < 3; i++) begin
				b[i] = coord();
				c[i] = coord();
			end
		end else if (kind == 1) begin
			for (int i = 0; i < 3; i++)
				c[i] = a[i] + 2 * (b[i] - a[i]);
		end
		return mk(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
	endfunction

	initial begin
		logic [THR_W-1:0] thr_list [6];
		plane_t none;
		none = '0;
		thr_list[0] = THR_RESET;
		thr_list[1] = 32'd0;
		thr_list[2] = 32'hFFFF_FFFF;
		thr_list[3] = $urandom;
		thr_list[4] = 32'd1 << 24;
		thr_list[5] = $urandom_range(0, 4000);
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		thr_now = THR_RESET;
		tx_idle = 1'b1;

		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, pl(16384, 16384, 16384, 0, 1));
		add_row(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607), 1, pl(16384, 16384, 16384, -25165821, 1));
		add_row(mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
			-8388608, -8388608, -8388608), 1, pl(16384, 16384, 16384, 25165824, 1));
		add_row(mk(0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1, pl(0, 0, 16384, 0, 0));
		add_row(mk(0, 0, 0, 0, 4096, 0, 4096, 0, 0), 1, pl(0, 0, -16384, 0, 0));
		add_row(mk(4096, 0, 0, 4096, 4096, 0, 4096, 0, 4096), 1, pl(16384, 0, 0, -4096, 0));
		add_row(mk(0, 0, 0, 4096, 0, 0, 0, 0, 4096), 1, pl(0, -16384, 0, 0, 0));
		add_row(mk(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, pl(16384, 16384, 16384, 0, 1));
		add_row(mk(0, 0, 0, 2, 0, 0, 0, 1, 0), 1, pl(0, 0, 16384, 0, 0));
		add_row(mk(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
			-8388608, 8388607, -8388608), 0, none);
		add_row(mk(8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
			8388607, -8388608, 8388607), 0, none);
		add_row(mk(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
			8388607, 8388607, -8388608), 0, none);
		add_row(mk(123456, -654321, 777, -5000000, 3, 8000000,
			8388607, -8388608, 1), 0, none);
		add_row(mk('h555555, 'h2AAAAA, -'h555556, -'h2AAAAB, 'h555555, 'h2AAAAA,
			'h123456, -'h555556, 'h7FFFFF), 0, none);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0)
				write_thr(thr_list[ph]);
			foreach (dir_rows[k])
				send_tri(dir_rows[k].t, dir_rows[k].typed && ph == 0, dir_rows[k].e);
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				if (k % 20 == 0)
					tx_idle = $urandom_range(0, 3) != 0;
				if (ph == 2 && k == RAND_PER_PHASE / 2)
					drain();
				send_tri(rand_tri(), 0, none);
			end
		end
		drain();
		if (mismatches == 0)
			$display("[triangle_plane_equation] OK");
		else
			$display("[triangle_plane_equation] ERROR");
		$finish;
	end

	initial begin
		int gap;
		m_tready = 1'b0;
		rx_idle = 1'b1;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_idle = !rx_idle;
			gap = rx_idle ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		plane_t got;
		plane_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.nx = m_tdata[15:0];
			got.ny = m_tdata[31:16];
			got.nz = m_tdata[47:32];
			got.off = m_tdata[73:48];
			got.degen = m_tuser;
			if (planes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: nx=%0d ny=%0d nz=%0d off=%0d degen=%0b",
						got.nx, got.ny, got.nz, got.off, got.degen);
			end else begin
				want = planes_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
							want.nx, want.ny, want.nz, want.off, want.degen,
							got.nx, got.ny, got.nz, got.off, got.degen);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[triangle_plane_equation] ERROR");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
	end
endmodule

>>> filelist.f
rtl/tep_pkg.sv
rtl/triangle_plane_equation.sv
sim/tb_triangle_plane_equation.sv
